/* rtl/core/imu_dfr_pkg.sv */
`default_nettype none

package imu_dfr_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'h7F;
    localparam logic [7:0]  SYNC_SECOND     = 8'h80;
    localparam int          PAYLOAD_LEN     = 20;
    localparam int          PAYLOAD_CNT_W   = $clog2(PAYLOAD_LEN);
    localparam int          NUM_WORDS       = PAYLOAD_LEN / 2;
    localparam int          YAW_WORD        = 8;
    localparam int          THRESHOLD_W     = 15;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 15'd1043;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_FAULT = 1'b1;

    typedef logic [15:0] word_t;

    // two's complement negate, modulo 65536
    function automatic word_t neg_wrap(input word_t v);
        return word_t'(~v + 16'd1);
    endfunction

    // negate, pinning the most negative value to the most positive
    function automatic word_t neg_sat(input word_t v);
        word_t r;
        if (v == 16'h8000) begin
            r = 16'h7FFF;
        end else begin
            r = word_t'(~v + 16'd1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/imu_frame_deframer_yaw_dejump.sv */
`default_nettype none

// Serial IMU deframer. Each input word carries one received byte (s_tuser = 0)
// or a link fault (s_tuser = 1, byte ignored), which sends the parser back to
// hunting for the 0x7F 0x80 sync pair while keeping the yaw state. After sync,
// 20 payload bytes are collected with an 8-bit running sum; the following byte
// must equal the inverted sum, otherwise the frame is dropped without output.
// A good frame gives one output word of ten signed 16-bit values (raw counts,
// y/z accel and rate negated with saturation, pitch and yaw negated modulo
// 65536) plus a jump flag in m_tuser set when the yaw offset was re-based
// because the wrapped yaw change exceeded yaw_jump_threshold (cfg_data, reset
// 1043). The block takes one input word per clock; the checksum byte waits in
// the input register while the parser and yaw logic work on it, and the output
// register then loads the result. Input stalls only while the output register
// holds a word that is not taken.
module imu_frame_deframer_yaw_dejump
    import imu_dfr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    input  wire logic                   s_tuser,   // [0] req_type

    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] gyro_x,
    // [79:64] gyro_y, [95:80] gyro_z, [111:96] roll_angle,
    // [127:112] pitch_angle, [143:128] yaw_angle, [159:144] temperature
    output      logic [159:0]           m_tdata,
    output      logic                   m_tuser,   // [0] jump_detected

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [THRESHOLD_W-1:0] cfg_data   // yaw_jump_threshold
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [PAYLOAD_CNT_W-1:0]   count_reg, count_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 payload_reg [PAYLOAD_LEN];
    word_t                      offset_reg, offset_next;
    word_t                      prev_yaw_reg, prev_yaw_next;
    logic                       seeded_reg, seeded_next;
    logic [THRESHOLD_W-1:0]     thr_reg;

    logic                       in_valid_reg, in_valid_next;
    logic                       in_type_reg;
    logic [7:0]                 in_byte_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [159:0]               m_data_reg;
    logic                       m_user_reg;

    logic                       advance;
    logic                       process;
    logic                       s_accept;
    logic                       good;

    word_t                      words [NUM_WORDS];
    word_t                      raw_yaw, prev_eff, yaw_sum, yaw_diff, yaw_new;
    logic [16:0]                yaw_mag;
    logic                       jump;
    logic [159:0]               frame_data;

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign process   = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            words[k] = {payload_reg[2*k+1], payload_reg[2*k]};
        end
    end

    // parser
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        good       = 1'b0;
        if (process) begin
            if (in_type_reg == REQ_FAULT) begin
                phase_next = PH_HUNT;
                count_next = '0;
                sum_next   = '0;
            end else begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (in_byte_reg == SYNC_FIRST) begin
                            phase_next = PH_SYNC;
                        end
                    end
                    PH_SYNC: begin
                        if (in_byte_reg == SYNC_SECOND) begin
                            count_next = '0;
                            sum_next   = '0;
                            phase_next = PH_DATA;
                        end else if (in_byte_reg != SYNC_FIRST) begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_DATA: begin
                        sum_next = sum_reg + in_byte_reg;
                        if (count_reg == PAYLOAD_CNT_W'(PAYLOAD_LEN - 1)) begin
                            count_next = '0;
                            phase_next = PH_CHECK;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    PH_CHECK: begin
                        good       = (~sum_reg == in_byte_reg);
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // yaw de-jump; the first frame compares against its own raw yaw
    always_comb begin
        raw_yaw  = words[YAW_WORD];
        prev_eff = seeded_reg ? prev_yaw_reg : raw_yaw;
        yaw_sum  = raw_yaw + offset_reg;
        yaw_diff = yaw_sum - prev_eff;
        yaw_mag  = yaw_diff[15] ? (17'h10000 - {1'b0, yaw_diff}) : {1'b0, yaw_diff};
        jump     = yaw_mag > {2'b00, thr_reg};
        yaw_new  = jump ? prev_eff : yaw_sum;

        offset_next   = offset_reg;
        prev_yaw_next = prev_yaw_reg;
        seeded_next   = seeded_reg;
        if (good) begin
            if (jump) begin
                offset_next = prev_eff - raw_yaw;
            end
            prev_yaw_next = yaw_new;
            seeded_next   = 1'b1;
        end

        frame_data = {words[9],
                      neg_wrap(yaw_new),
                      neg_wrap(words[7]),
                      words[6],
                      neg_sat(words[5]),
                      neg_sat(words[4]),
                      words[3],
                      neg_sat(words[2]),
                      neg_sat(words[1]),
                      words[0]};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (good) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            count_reg    <= '0;
            sum_reg      <= '0;
            offset_reg   <= '0;
            prev_yaw_reg <= '0;
            seeded_reg   <= 1'b0;
            thr_reg      <= THRESHOLD_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            offset_reg   <= offset_next;
            prev_yaw_reg <= prev_yaw_next;
            seeded_reg   <= seeded_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
        end
    end

    // payload and datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (process && in_type_reg == REQ_BYTE && phase_reg == PH_DATA) begin
            payload_reg[count_reg] <= in_byte_reg;
        end
        if (good) begin
            m_data_reg <= frame_data;
            m_user_reg <= jump;
        end
    end

    // a result only follows a checksum byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(phase_reg == PH_CHECK))
        else $error("result without checksum phase");

    // while valid, output yaw is always the negated stored last yaw
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[143:128] == neg_wrap(prev_yaw_reg)))
        else $error("output yaw out of step with last yaw");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> seeded_reg)
        else $error("result before yaw seeded");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= PAYLOAD_CNT_W'(PAYLOAD_LEN - 1))
        else $error("payload count out of range");

    // a fault never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_type_reg == REQ_FAULT) |=> phase_reg == PH_HUNT && !$rose(m_valid_reg))
        else $error("link fault not handled");

endmodule

`default_nettype wire

/* sim/imu_frame_deframer_yaw_dejump_tb.sv */
`timescale 1ns / 100ps

module imu_frame_deframer_yaw_dejump_tb;
    import imu_dfr_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 310;
    localparam int NUM_PHASES   = 5;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } rx_word_t;

    typedef struct packed {
        logic [16*NUM_WORDS-1:0] data;
        logic                    jump;
    } imu_frame_t;

    typedef enum logic [1:0] {ST_HUNT, ST_SYNC2, ST_PAYLOAD, ST_CHECKSUM} parse_state_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'h00;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [159:0]           m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [THRESHOLD_W-1:0] cfg_data = '0;

    imu_frame_deframer_yaw_dejump uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    string out_field_name [NUM_WORDS] = '{"accel_x", "accel_y", "accel_z", "gyro_x",
                                          "gyro_y", "gyro_z", "roll_angle", "pitch_angle",
                                          "yaw_angle", "temperature"};

    rx_word_t   byte_q[$];
    imu_frame_t frame_q[$];
    rx_word_t   in_flight;
    int         items_queued = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         gaps_on = 1'b1;
    bit         hold_armed = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    logic [15:0] gen_yaw;

    // parser and yaw tracker mirror
    parse_state_t     parse_st = ST_HUNT;
    int               pay_cnt = 0;
    logic [7:0]       pay_sum = 8'h00;
    logic [7:0]       pay_bytes [PAYLOAD_LEN];
    logic [15:0]      yaw_base = 16'h0000;
    logic [15:0]      yaw_prev = 16'h0000;
    bit               yaw_seeded = 1'b0;
    logic [THRESHOLD_W-1:0] yaw_limit = THRESHOLD_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] negate_wrap(input logic [15:0] v);
        return 16'h0000 - v;
    endfunction

    function automatic logic [15:0] negate_sat(input logic [15:0] v);
        return (v == 16'h8000) ? 16'h7FFF : 16'h0000 - v;
    endfunction

    function automatic void deframe_byte(input logic req, input logic [7:0] b);
        logic [15:0] w [NUM_WORDS];
        logic [15:0] raw;
        logic [15:0] ynew;
        logic [15:0] diff;
        logic [16:0] mag;
        logic [7:0]  chk;
        imu_frame_t  res;
        if (req == REQ_FAULT) begin
            parse_st = ST_HUNT;
            pay_cnt = 0;
            pay_sum = 8'h00;
        end else begin
            case (parse_st)
                ST_HUNT: begin
                    if (b == SYNC_FIRST) parse_st = ST_SYNC2;
                end
                ST_SYNC2: begin
                    if (b == SYNC_SECOND) begin
                        pay_cnt = 0;
                        pay_sum = 8'h00;
                        parse_st = ST_PAYLOAD;
                    end else if (b != SYNC_FIRST) begin
                        parse_st = ST_HUNT;
                    end
                end
                ST_PAYLOAD: begin
                    pay_bytes[pay_cnt] = b;
                    pay_sum = pay_sum + b;
                    pay_cnt++;
                    if (pay_cnt == PAYLOAD_LEN) parse_st = ST_CHECKSUM;
                end
                default: begin
                    parse_st = ST_HUNT;
                    chk = ~pay_sum;
                    if (b == chk) begin
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            w[k] = {pay_bytes[2*k+1], pay_bytes[2*k]};
                        end
                        raw = w[YAW_WORD];
                        res.jump = 1'b0;
                        if (!yaw_seeded) begin
                            yaw_prev = raw;
                            yaw_seeded = 1'b1;
                        end
                        ynew = raw + yaw_base;
                        diff = ynew - yaw_prev;
                        mag = diff[15] ? 17'h10000 - {1'b0, diff} : {1'b0, diff};
                        // re-base so this frame continues from the last yaw
                        if (mag > {2'b00, yaw_limit}) begin
                            yaw_base = yaw_prev - raw;
                            ynew = raw + yaw_base;
                            res.jump = 1'b1;
                        end
                        yaw_prev = ynew;
                        res.data = {w[9], negate_wrap(ynew), negate_wrap(w[7]), w[6],
                                    negate_sat(w[5]), negate_sat(w[4]), w[3],
                                    negate_sat(w[2]), negate_sat(w[1]), w[0]};
                        frame_q.insert(frame_q.size(), res);
                    end
                end
            endcase
        end
    endfunction

    function automatic void send_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), rx_word_t'{req: REQ_BYTE, data: b});
        items_queued++;
    endfunction

    function automatic void send_fault(input logic [7:0] junk);
        byte_q.insert(byte_q.size(), rx_word_t'{req: REQ_FAULT, data: junk});
        items_queued++;
    endfunction

    function automatic void send_frame(input logic [16*NUM_WORDS-1:0] words, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            b = words[8*i +: 8];
            sum = sum + b;
            send_byte(b);
        end
        b = ~sum;
        if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
    endfunction

    // lean toward the extreme codes, yaw placed by the caller
    function automatic logic [16*NUM_WORDS-1:0] random_words(input logic [15:0] yaw);
        logic [16*NUM_WORDS-1:0] w;
        for (int k = 0; k < NUM_WORDS; k++) begin
            case ($urandom_range(9))
                0: w[16*k +: 16] = 16'h8000;
                1: w[16*k +: 16] = 16'h7FFF;
                2: w[16*k +: 16] = 16'h0000;
                3: w[16*k +: 16] = 16'hFFFF;
                default: w[16*k +: 16] = 16'($urandom);
            endcase
        end
        w[16*YAW_WORD +: 16] = yaw;
        return w;
    endfunction

    task automatic fill_random(input int n_items, input int thr);
        int stop;
        int r;
        int m;
        logic [15:0] step;
        stop = items_queued + n_items;
        while (items_queued < stop) begin
            r = $urandom_range(99);
            if (r < 70) begin
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)));
                repeat ($urandom_range(0, 2)) send_byte(SYNC_FIRST);
                // yaw change per frame: mostly in range, some at the limit, some wild
                r = $urandom_range(99);
                if (r < 50) begin
                    m = $urandom_range(0, thr);
                end else if (r < 70) begin
                    m = thr + $urandom_range(0, 2) - 1;
                end else if (r < 90) begin
                    m = $urandom_range(0, 32767);
                end else begin
                    m = 32768;
                end
                step = $urandom_range(1) ? 16'(-m) : 16'(m);
                gen_yaw = gen_yaw + step;
                send_frame(random_words(gen_yaw), 1'b0);
            end else if (r < 80) begin
                send_frame(random_words(16'($urandom)), 1'b1);
            end else if (r < 88) begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                repeat ($urandom_range(0, PAYLOAD_LEN)) send_byte(8'($urandom_range(255)));
                send_fault(8'($urandom_range(255)));
            end else if (r < 94) begin
                send_fault(8'($urandom_range(255)));
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            end
        end
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || s_tvalid || frame_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input int v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= THRESHOLD_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        yaw_limit = THRESHOLD_W'(v);
        @(negedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        bit gap;
        gap = gaps_on && ($urandom_range(99) < 30);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) deframe_byte(in_flight.req, in_flight.data);
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && !gap) begin
                    in_flight = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= in_flight.data;
                    s_tuser <= in_flight.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge aclk) begin
        imu_frame_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_q.size() == 0) begin
                    $error("output word with no frame pending");
                    mismatches++;
                end else begin
                    want = frame_q.pop_front();
                    for (int k = 0; k < NUM_WORDS; k++) begin
                        if (m_tdata[16*k +: 16] !== want.data[16*k +: 16]) begin
                            $error("%s: expected %0d, got %0d", out_field_name[k],
                                   $signed(want.data[16*k +: 16]),
                                   $signed(m_tdata[16*k +: 16]));
                            mismatches++;
                        end
                    end
                    if (m_tuser !== want.jump) begin
                        $error("jump_detected: expected %0d, got %0d", want.jump, m_tuser);
                        mismatches++;
                    end
                end
            end
            // hold off once for a long stretch so the block backs up
            if (hold_armed && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && ($urandom_range(99) < 30));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("imu_frame_deframer_yaw_dejump_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int thr_set [NUM_PHASES];
        thr_set = '{0, 32767, 0, 1, 1043};
        thr_set[2] = $urandom_range(2, 32766);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: fault, stray sync byte, repeated first sync, first frame at extremes
        send_fault(8'hFF);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame({16'h7FFF, 16'h1234, 16'h8000, 16'h8000, 16'hFFFF,
                    16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}, 1'b0);
        send_frame({16'h7FFF, 16'h1234, 16'h8000, 16'h8000, 16'hFFFF,
                    16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}, 1'b1);
        // cut a frame short with a link fault
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat (7) send_byte(8'hA5);
        send_fault(8'h00);
        // half-turn yaw change always re-bases
        send_frame({16'h8000, 16'h9234, 16'h0001, 16'hFFFF, 16'h8000,
                    16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF}, 1'b0);
        send_byte(SYNC_FIRST);
        send_byte(8'h55);
        // exactly at the limit, then one past it
        send_frame(random_words(16'h9647), 1'b0);
        send_frame(random_words(16'h9A5B), 1'b0);
        gen_yaw = 16'h9A5B;
        @(negedge aclk);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_threshold(thr_set[ph]);
            gaps_on = (ph != 1);
            if (ph == 0) hold_armed = 1'b1;
            fill_random(PHASE_ITEMS, thr_set[ph]);
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("imu_frame_deframer_yaw_dejump_tb: done, clean");
        end else begin
            $display("imu_frame_deframer_yaw_dejump_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/imu_dfr_pkg.sv
rtl/core/imu_frame_deframer_yaw_dejump.sv
sim/imu_frame_deframer_yaw_dejump_tb.sv
